### hdl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  typedef logic [127:0] blk_t;

  localparam int unsigned NumRounds = 10;

  // Cycles the registered key schedule needs before the last round key is valid.
  localparam int unsigned KeySettleCycles = NumRounds + 1;

  typedef enum logic [0:0] {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_e;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rev_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits at bits 127-8i.
  function automatic logic [7:0] byte_of(input blk_t s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t next_key(input blk_t k, input logic [3:0] r);
    blk_t o;
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    t = {sbox(w[3][23:16]) ^ rcon(r), sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    o = {w[0], w[1], w[2], w[3]};
    return o;
  endfunction

  // One forward round: SubBytes, ShiftRows, optional MixColumns.
  function automatic blk_t enc_round(input blk_t s, input logic last);
    blk_t o;
    logic [7:0] b [16];
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) b[4 * c + r] = sbox(byte_of(s, 4 * ((c + r) % 4) + r));
    for (int c = 0; c < 4; c++) begin
      a0 = b[4 * c]; a1 = b[4 * c + 1]; a2 = b[4 * c + 2]; a3 = b[4 * c + 3];
      if (!last) begin
        b[4 * c]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        b[4 * c + 1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        b[4 * c + 2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        b[4 * c + 3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = b[i];
    return o;
  endfunction

  // One inverse round: InvShiftRows, InvSubBytes, key add, optional InvMixColumns.
  function automatic blk_t dec_round(input blk_t s, input blk_t k, input logic last);
    blk_t o;
    logic [7:0] b [16];
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        b[4 * c + r] = rev_sbox(byte_of(s, 4 * ((c + 3 * r) % 4) + r)) ^ byte_of(k, 4 * c + r);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = b[4 * c + r];
        x2[r] = xt(a[r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
      end
      if (!last) begin
        for (int r = 0; r < 4; r++) begin
          // coefficients 14, 11, 13, 9 rotate with the row
          b[4 * c + r] = (x8[r] ^ x4[r] ^ x2[r])
                       ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
                       ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
                       ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
        end
      end
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = b[i];
    return o;
  endfunction

endpackage

### hdl/aes_keysched.sv
`timescale 1ns / 1ps
module aes_keysched (
  input  logic          clk_i,
  input  aes_pkg::blk_t key_i,
  output aes_pkg::blk_t rk_o [aes_pkg::NumRounds + 1]
);

  // The user changes the key only while the pipeline is empty (not enforced);
  // each round key is registered so that one expansion step stands between them.
  aes_pkg::blk_t rk_q [aes_pkg::NumRounds + 1];

  always_ff @(posedge clk_i) begin
    rk_q[0] <= key_i;
    for (int r = 1; r <= aes_pkg::NumRounds; r++) begin
      rk_q[r] <= aes_pkg::next_key(rk_q[r - 1], 4'(r));
    end
  end

  assign rk_o = rk_q;

endmodule

### hdl/aes128_block_cipher.sv
`timescale 1ns / 1ps
// AES-128 block cipher, electronic codebook, fully unrolled pipeline.
// Input channel: in_valid_i / in_stall_o with operation_i (0 encrypts,
// 1 decrypts), block_high_i and block_low_i. A beat is taken at a clock
// edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i with result_high_o and result_low_o.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 key_high,
// 1 key_low) and cfg_data_i; other indexes are dropped. Keys are written
// only while the pipeline is empty, a rule for the user that the block does
// not enforce. The round keys are rebuilt one per cycle, so after reset and
// after every key write the input stalls until the last round key is valid.
// From input beat to output beat a block passes one key-add stage, ten
// round stages (one AES round per register stage) and the output register.
// Throughput is one beat per cycle while in_stall_o is low; each
// stage holds one block and a valid bit, and a stage advances when the
// stage after it is empty or advancing, so a stalled receiver freezes the
// pipe from the tail and stall propagates back to the input without losing
// or repeating a beat.
// Reset clears the keys to zero and empties every stage.
module aes128_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned NStg = aes_pkg::NumRounds + 2;

  logic [63:0] key_hi_q, key_lo_q;
  aes_pkg::blk_t rk [aes_pkg::NumRounds + 1];

  // Counts down while the round keys are being rebuilt.
  logic [3:0] settle_q;

  // Stage 0 holds the block after the first key add; stages 1..10 the
  // rounds; stage 11 is the output register.
  aes_pkg::blk_t st_q [NStg];
  logic          op_q [aes_pkg::NumRounds];
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (aes_pkg::reg_e'(cfg_index_i))
        aes_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        aes_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 4'(aes_pkg::KeySettleCycles);
    end else if (cfg_valid_i && cfg_ready_o) begin
      settle_q <= 4'(aes_pkg::KeySettleCycles);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 4'd1;
    end
  end

  aes_keysched u_keysched (
    .clk_i (clk_i),
    .key_i ({key_hi_q, key_lo_q}),
    .rk_o  (rk)
  );

  // Stage i loads when it is empty or its content moves on.
  always_comb begin
    adv[NStg-1] = !vld_q[NStg-1] || !out_stall_i;
    for (int i = NStg - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i + 1];
    end
  end

  assign in_stall_o = !adv[0] || (settle_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= adv[0] ? (in_valid_i && (settle_q == '0)) : vld_q[0];
      for (int i = 1; i < NStg; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i - 1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      op_q[0] <= operation_i;
      st_q[0] <= {block_high_i, block_low_i} ^
                 ((aes_pkg::op_e'(operation_i) == aes_pkg::OP_ENC) ? rk[0]
                                                                  : rk[aes_pkg::NumRounds]);
    end
    for (int r = 1; r <= aes_pkg::NumRounds; r++) begin
      if (adv[r]) begin
        if (r < aes_pkg::NumRounds) op_q[r] <= op_q[r - 1];
        if (aes_pkg::op_e'(op_q[r - 1]) == aes_pkg::OP_ENC) begin
          st_q[r] <= aes_pkg::enc_round(st_q[r - 1], r == aes_pkg::NumRounds) ^ rk[r];
        end else begin
          st_q[r] <= aes_pkg::dec_round(st_q[r - 1], rk[aes_pkg::NumRounds - r],
                                        r == aes_pkg::NumRounds);
        end
      end
    end
    if (adv[NStg-1]) begin
      st_q[NStg-1] <= st_q[NStg-2];
    end
  end

  assign out_valid_o   = vld_q[NStg-1];
  assign result_high_o = st_q[NStg-1][127:64];
  assign result_low_o  = st_q[NStg-1][63:0];

  // A stalled output stage keeps its beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_high_o))
    else $error("output beat lost under stall");

  // Once the keys are settled, input stall only arises when the whole pipe is full.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && (settle_q == '0) |-> (&vld_q) && out_stall_i)
    else $error("input stalled with room in the pipe");

  // Every accepted beat reaches stage 0 next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted beat not captured");

endmodule

### tb/sv/aes128_block_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the AES-128 ECB cipher pipeline.
module aes128_block_cipher_tb;

  // A stimulus row carries the key under which it runs, the beat itself, and
  // optionally a known answer typed in from the standard test vectors.
  typedef struct {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    aes_pkg::op_e op;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic        known;
    logic [127:0] answer;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = aes_pkg::REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  // Known-answer tag travels alongside the payload so the monitor can pick it
  // up at the same edge where the beat is accepted.
  logic        cur_known = 1'b0;
  logic [127:0] cur_answer = '0;

  // Bench-side copy of the two key registers.
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;

  logic [7:0] fwd_sub [256];
  logic [7:0] rev_sub [256];

  logic [127:0] cipher_expect_q [$];
  row_t         directed_rows [$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           enc_beats = 0;
  int           dec_beats = 0;
  int           key_writes = 0;
  bit           long_hold_done = 1'b0;

  aes128_block_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .block_high_i  (block_high),
    .block_low_i   (block_low),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_high_o (result_high),
    .result_low_o  (result_low),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor. GF(2^8) arithmetic is done bit-serially; the S-box is built
  // from the multiplicative inverse plus the affine map, and the inverse
  // S-box by inverting that table.
  // ---------------------------------------------------------------------
  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_double(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  initial begin
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      if (x == 0) inv = 8'h00;
      else repeat (254) inv = gf_mul(inv, x[7:0]);
      fwd_sub[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                 ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) rev_sub[fwd_sub[x]] = x[7:0];
  end

  // Rows of the state rotate left for encryption and right for decryption.
  function automatic void rotate_rows(ref logic [7:0] st [16], input int dir);
    logic [7:0] t [16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[c * 4 + r] = st[((c + r * dir) & 3) * 4 + r];
    st = t;
  endfunction

  function automatic void mix_state(ref logic [7:0] st [16], input bit inverse);
    logic [7:0] coef [4];
    logic [7:0] t [4];
    logic [7:0] acc;
    if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(st[c * 4 + k], coef[(k - r) & 3]);
        t[r] = acc;
      end
      for (int r = 0; r < 4; r++) st[c * 4 + r] = t[r];
    end
  endfunction

  function automatic logic [127:0] aes_cipher_block(input aes_pkg::op_e op,
                                                    input logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] w [4];
    logic [7:0] w0;
    logic [7:0] rc;
    logic [127:0] key;
    logic [127:0] res;
    key = {key_hi_q, key_lo_q};
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8 * i -: 8];
      st[i] = blk[127 - 8 * i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4 * (i - 1) + j];
      if ((i & 3) == 0) begin
        w0 = w[0];
        w[0] = fwd_sub[w[1]] ^ rc;
        w[1] = fwd_sub[w[2]];
        w[2] = fwd_sub[w[3]];
        w[3] = fwd_sub[w0];
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 4) + j] ^ w[j];
    end
    if (op == aes_pkg::OP_ENC) begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) st[i] = fwd_sub[st[i]];
        rotate_rows(st, 1);
        if (r < 10) mix_state(st, 1'b0);
        for (int i = 0; i < 16; i++) st[i] ^= rk[16 * r + i];
      end
    end else begin
      for (int i = 0; i < 16; i++) st[i] ^= rk[160 + i];
      for (int r = 9; r >= 0; r--) begin
        rotate_rows(st, 3);
        for (int i = 0; i < 16; i++) st[i] = rev_sub[st[i]];
        for (int i = 0; i < 16; i++) st[i] ^= rk[16 * r + i];
        if (r > 0) mix_state(st, 1'b1);
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge, before any of
  // this edge's nonblocking updates land, so accept decisions see the same
  // values the DUT saw.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        if (cur_known) cipher_expect_q = {cipher_expect_q, cur_answer};
        else cipher_expect_q = {cipher_expect_q,
                                aes_cipher_block(aes_pkg::op_e'(operation),
                                                 {block_high, block_low})};
        if (operation == aes_pkg::OP_ENC) enc_beats++;
        else dec_beats++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (cipher_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result beat %h_%h with nothing outstanding",
                     result_high, result_low);
        end else begin
          want = cipher_expect_q.pop_front();
          if (result_high !== want[127:64] || result_low !== want[63:0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected %h_%h got %h_%h", results_seen,
                       want[127:64], want[63:0], result_high, result_low);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver stall pattern. It mixes free-running stretches, random stalls
  // and, once the random traffic is under way, a long hold-off so that the
  // pipeline fills and the input side has to stall.
  // ---------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    @(posedge rst_ni);
    forever begin
      mode = (!long_hold_done && (enc_beats + dec_beats >= 60)) ? 0 : $urandom_range(1, 9);
      span = $urandom_range(20, 60);
      if (mode == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(60, 90)) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (mode <= 3) begin
        out_stall <= 1'b0;
        repeat (span) @(posedge clk_i);
      end else begin
        repeat (span) begin
          out_stall <= ($urandom_range(0, 9) < 3);
          @(posedge clk_i);
        end
      end
    end
  end

  // Raise valid with the given beat and hold it until the DUT takes it.
  task automatic offer_beat(input aes_pkg::op_e op, input logic [127:0] blk,
                            input logic known, input logic [127:0] answer);
    in_valid   <= 1'b1;
    operation  <= op;
    block_high <= blk[127:64];
    block_low  <= blk[63:0];
    cur_known  <= known;
    cur_answer <= answer;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Keys change only with the pipe empty; afterwards the round keys need
  // to settle before the next beat may enter.
  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
    for (int idx = 0; idx < 2; idx++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (idx == 0) ? aes_pkg::REG_KEY_HIGH : aes_pkg::REG_KEY_LOW;
      cfg_data  <= (idx == 0) ? hi : lo;
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      if (idx == 0) key_hi_q = hi;
      else key_lo_q = lo;
      key_writes++;
    end
    cfg_valid <= 1'b0;
    repeat (16) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [127:0] key, input aes_pkg::op_e op,
                         input logic [127:0] blk,
                         input logic known, input logic [127:0] answer);
    row_t r;
    r.key_hi = key[127:64];
    r.key_lo = key[63:0];
    r.op     = op;
    r.blk_hi = blk[127:64];
    r.blk_lo = blk[63:0];
    r.known  = known;
    r.answer = answer;
    directed_rows = {directed_rows, r};
  endtask

  // Hard limit on the whole run.
  initial begin
    #3ms;
    $display("ERROR: run timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [127:0] zero_k;
    logic [127:0] ones;
    logic [127:0] fips_k;
    logic [127:0] rand_blk;
    logic [63:0]  khi;
    logic [63:0]  klo;
    int           burst;
    int           drain;
    zero_k = '0;
    ones   = '1;
    fips_k = 128'h000102030405060708090a0b0c0d0e0f;

    // Zero key is the reset value, so the first rows run without a write.
    add_row(zero_k, aes_pkg::OP_ENC, '0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
    add_row(zero_k, aes_pkg::OP_DEC, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, '0);
    add_row(zero_k, aes_pkg::OP_ENC, ones, 1'b0, '0);
    add_row(zero_k, aes_pkg::OP_DEC, ones, 1'b0, '0);
    add_row(fips_k, aes_pkg::OP_ENC, 128'h00112233445566778899aabbccddeeff, 1'b1,
            128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    add_row(fips_k, aes_pkg::OP_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
            128'h00112233445566778899aabbccddeeff);
    add_row(fips_k, aes_pkg::OP_ENC, {4{32'haaaa5555}}, 1'b0, '0);
    add_row(fips_k, aes_pkg::OP_DEC, {4{32'h5555aaaa}}, 1'b0, '0);
    add_row(fips_k, aes_pkg::OP_ENC, '0, 1'b0, '0);
    add_row(128'h2b7e151628aed2a6abf7158809cf4f3c, aes_pkg::OP_ENC,
            128'h3243f6a8885a308d313198a2e0370734, 1'b1,
            128'h3925841d02dc09fbdc118597196a0b32);
    add_row(128'h2b7e151628aed2a6abf7158809cf4f3c, aes_pkg::OP_DEC,
            128'h3925841d02dc09fbdc118597196a0b32, 1'b1,
            128'h3243f6a8885a308d313198a2e0370734);
    add_row(ones, aes_pkg::OP_ENC, '0, 1'b0, '0);
    add_row(ones, aes_pkg::OP_DEC, '0, 1'b0, '0);
    add_row(ones, aes_pkg::OP_ENC, ones, 1'b0, '0);
    add_row(ones, aes_pkg::OP_DEC, ones, 1'b0, '0);
    add_row(ones, aes_pkg::OP_ENC, 128'h80000000000000000000000000000001, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (16) @(posedge clk_i);

    // Directed rows, back to back within one key.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].key_hi != key_hi_q || directed_rows[i].key_lo != key_lo_q)
        load_key(directed_rows[i].key_hi, directed_rows[i].key_lo);
      offer_beat(directed_rows[i].op, {directed_rows[i].blk_hi, directed_rows[i].blk_lo},
                 directed_rows[i].known, directed_rows[i].answer);
    end

    // Random traffic in four key phases, the last one returning to zero.
    for (int phase = 0; phase < 4; phase++) begin
      khi = {$urandom, $urandom};
      klo = {$urandom, $urandom};
      if (phase == 3) begin
        khi = '0;
        klo = '0;
      end
      load_key(khi, klo);
      burst = 0;
      for (int n = 0; n < 110; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk_i);
          end
        end
        burst--;
        rand_blk = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 15))
          0: rand_blk = '0;
          1: rand_blk = '1;
          default: ;
        endcase
        offer_beat(aes_pkg::op_e'($urandom_range(0, 1)), rand_blk, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (cipher_expect_q.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);

    $display("Covered %0d encrypt and %0d decrypt beats, %0d results, %0d key writes.",
             enc_beats, dec_beats, results_seen, key_writes);
    $display("Long receiver hold-off exercised: %0d, mismatches: %0d, left over: %0d",
             long_hold_done, mismatches, cipher_expect_q.size());
    if (mismatches == 0 && cipher_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
